// ----- hw/rtl/wcl_pkg.sv -----
// Shared widths, constants and types for the windowed CPU load block.
// No dependencies; used by wcl_pct_div and windowed_cpu_load_percent.
package wcl_pkg;

    localparam int TICK_W      = 48;
    localparam int HIST_W      = 50;
    localparam int PCT_W       = 7;
    localparam int PROD_W      = HIST_W + PCT_W;
    localparam int IN_TDATA_W  = 4 * TICK_W;
    localparam int OUT_TDATA_W = 8;

    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    typedef struct packed {
        logic              start;
        logic              kill;
        logic [HIST_W-1:0] num;
        logic [HIST_W-1:0] den;
    } wcl_div_req_t;

endpackage

// ----- hw/rtl/wcl_pct_div.sv -----
// Percent unit: scales the busy delta by 100 and divides by the total delta,
// one quotient bit per cycle, with saturation at 100. Depends on wcl_pkg.
module wcl_pct_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wcl_pkg::wcl_div_req_t       req,
    output logic                        done,
    output logic [wcl_pkg::PCT_W-1:0]   pct
);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_SCALE = 2'd1;
    localparam logic [1:0] D_STEP  = 2'd2;

    localparam int CNT_W = $clog2(wcl_pkg::PCT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(wcl_pkg::PCT_W - 1);

    logic [1:0]                   state_reg, state_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         kill_reg, kill_next;
    logic                         sat_reg, sat_next;
    logic [wcl_pkg::HIST_W-1:0]   num_reg, num_next;
    logic [wcl_pkg::HIST_W-1:0]   den_reg, den_next;
    logic [wcl_pkg::PROD_W-1:0]   rem_reg, rem_next;
    logic [wcl_pkg::PROD_W-1:0]   div_reg, div_next;
    logic [wcl_pkg::PCT_W-1:0]    quo_reg, quo_next;
    logic [wcl_pkg::PROD_W-1:0]   prod;

    // times one hundred as 64 + 32 + 4
    assign prod = wcl_pkg::PROD_W'({num_reg, 6'b0})
                + wcl_pkg::PROD_W'({num_reg, 5'b0})
                + wcl_pkg::PROD_W'({num_reg, 2'b0});

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        kill_next  = kill_reg;
        sat_next   = sat_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    num_next   = req.num;
                    den_next   = req.den;
                    kill_next  = req.kill;
                    state_next = D_SCALE;
                end
            end
            D_SCALE: begin
                rem_next   = prod;
                div_next   = wcl_pkg::PROD_W'({den_reg, {(wcl_pkg::PCT_W-1){1'b0}}});
                kill_next  = kill_reg | (den_reg == '0);
                sat_next   = (num_reg >= den_reg);
                cnt_next   = '0;
                quo_next   = '0;
                state_next = D_STEP;
            end
            D_STEP: begin
                if (rem_reg >= div_reg) begin
                    rem_next = rem_reg - div_reg;
                    quo_next = {quo_reg[wcl_pkg::PCT_W-2:0], 1'b1};
                end else begin
                    quo_next = {quo_reg[wcl_pkg::PCT_W-2:0], 1'b0};
                end
                div_next = div_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        kill_reg <= kill_next;
        sat_reg  <= sat_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign pct  = kill_reg ? '0 : (sat_reg ? wcl_pkg::PCT_SCALE : quo_reg);

endmodule

// ----- hw/rtl/windowed_cpu_load_percent.sv -----
// Windowed CPU load: ring history of (busy, total) snapshots in one memory,
// percent of busy ticks over the window. Depends on wcl_pkg, wcl_pct_div.
//
// channel  dir  tdata fields (lowest bit up)                         tuser
// s_       in   user_ticks, nice_ticks, system_ticks, idle_ticks     -
// m_       out  load_percent, one zero pad bit                       -
//
// An item passes through the load, total, diff, calc and out states in turn,
// and no new item is accepted before its result enters the output register;
// the seven-step quotient loop in wcl_pct_div takes most of that time.
// Reset clears the pointer and the per-entry valid bits; an invalid entry
// reads as zero. A stalled result holds in the output register while the
// next item is accepted.
module windowed_cpu_load_percent #(
    parameter int WINDOW = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // user_ticks, nice_ticks, system_ticks, idle_ticks
    input  logic [wcl_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // load_percent, zero pad
    output logic [wcl_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TW    = wcl_pkg::TICK_W;
    localparam int HW    = wcl_pkg::HIST_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_TOTAL = 3'd2;
    localparam logic [2:0] S_DIFF  = 3'd3;
    localparam logic [2:0] S_CALC  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [PTR_W-1:0]         ptr_reg, ptr_next;
    logic [WINDOW-1:0]        valid_reg, valid_next;
    logic [TW-1:0]            user_reg, nice_reg, system_reg, idle_reg;
    logic [HW-1:0]            busy_reg, busy_next;
    logic [HW-1:0]            total_reg, total_next;
    logic [wcl_pkg::PCT_W-1:0] pct_reg, pct_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [wcl_pkg::PCT_W-1:0] m_pct_reg, m_pct_next;

    logic [2*HW-1:0]          hist_mem [WINDOW];
    logic [2*HW-1:0]          rd_pair_reg;
    logic                     rd_valid_reg;
    logic                     rd_en, wr_en;

    logic                     s_accept;
    logic [HW-1:0]            old_busy, old_total;
    logic [HW:0]              busy_diff, total_diff;
    wcl_pkg::wcl_div_req_t    div_req;
    logic                     div_done;
    logic [wcl_pkg::PCT_W-1:0] div_pct;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign rd_en    = s_accept;
    assign wr_en    = (state_reg == S_DIFF);

    assign old_busy   = rd_valid_reg ? rd_pair_reg[2*HW-1:HW] : '0;
    assign old_total  = rd_valid_reg ? rd_pair_reg[HW-1:0]    : '0;
    assign busy_diff  = {1'b0, busy_reg}  - {1'b0, old_busy};
    assign total_diff = {1'b0, total_reg} - {1'b0, old_total};

    // drop the item when the slot is empty or either counter goes back
    assign div_req.start = wr_en;
    assign div_req.kill  = (old_total == '0) | total_diff[HW] | busy_diff[HW];
    assign div_req.num   = busy_diff[HW-1:0];
    assign div_req.den   = total_diff[HW-1:0];

    wcl_pct_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .pct     (div_pct)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[ptr_reg] <= {busy_reg, total_reg};
        end
        if (rd_en) begin
            rd_pair_reg <= hist_mem[ptr_reg];
        end
    end

    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        valid_next    = valid_reg;
        busy_next     = busy_reg;
        total_next    = total_reg;
        pct_next      = pct_reg;
        m_pct_next    = m_pct_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                busy_next  = HW'(user_reg) + HW'(nice_reg) + HW'(system_reg);
                state_next = S_TOTAL;
            end
            S_TOTAL: begin
                total_next = busy_reg + HW'(idle_reg);
                state_next = S_DIFF;
            end
            S_DIFF: begin
                valid_next[ptr_reg] = 1'b1;
                if (ptr_reg == PTR_W'(WINDOW - 1)) begin
                    ptr_next = '0;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
                state_next = S_CALC;
            end
            S_CALC: begin
                if (div_done) begin
                    pct_next   = div_pct;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_pct_next    = pct_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ptr_reg      <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            user_reg     <= s_tdata[TW-1:0];
            nice_reg     <= s_tdata[2*TW-1:TW];
            system_reg   <= s_tdata[3*TW-1:2*TW];
            idle_reg     <= s_tdata[4*TW-1:3*TW];
            rd_valid_reg <= valid_reg[ptr_reg];
        end
        busy_reg  <= busy_next;
        total_reg <= total_next;
        pct_reg   <= pct_next;
        m_pct_reg <= m_pct_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(wcl_pkg::OUT_TDATA_W - wcl_pkg::PCT_W){1'b0}}, m_pct_reg};

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == S_LOAD)
        else $error("accepted item did not start processing");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output step");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> m_pct_reg <= wcl_pkg::PCT_SCALE)
        else $error("load percent above 100");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PTR_W'(WINDOW - 1))
        else $error("ring pointer out of range");

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_CALC)
        else $error("divider finished while no item waits for it");
`endif

endmodule
